### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, sampled on clock, off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

### hw/rtl/lpwf_pkg.sv
// ----------------------------------------------------------------------------
// lpwf_pkg
// shared widths, register codes, reset values and types of the point filter
// ----------------------------------------------------------------------------
package lpwf_pkg;

   localparam int COORD_BITS     = 24;
   localparam int ID_BITS        = 8;
   localparam int RANGE_BITS     = 24;
   localparam int INTEN_BITS     = 16;
   localparam int COUNT_BITS     = 4;
   localparam int RPC_BITS       = 5;
   localparam int CSR_DATA_BITS  = 48;
   localparam int CSR_INDEX_BITS = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_X_BOUNDS         = 3'd0,
      REG_Y_BOUNDS         = 3'd1,
      REG_Z_BOUNDS         = 3'd2,
      REG_DISTANCE_BOUNDS  = 3'd3,
      REG_INTENSITY_BOUNDS = 3'd4,
      REG_RETURN_FILTER_ON = 3'd5,
      REG_RETURNS_PER_CYC  = 3'd6,
      REG_KEPT_RETURN      = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x_max;
      logic signed [COORD_BITS-1:0] x_min;
      logic signed [COORD_BITS-1:0] y_max;
      logic signed [COORD_BITS-1:0] y_min;
      logic signed [COORD_BITS-1:0] z_max;
      logic signed [COORD_BITS-1:0] z_min;
      logic [RANGE_BITS-1:0]        range_max;
      logic [RANGE_BITS-1:0]        range_min;
      logic [INTEN_BITS-1:0]        inten_max;
      logic [INTEN_BITS-1:0]        inten_min;
      logic                         return_filter_on;
      logic [RPC_BITS-1:0]          returns_per_cycle;
      logic [COUNT_BITS-1:0]        kept_return;
   } cfg_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] point_x;
      logic signed [COORD_BITS-1:0] point_y;
      logic signed [COORD_BITS-1:0] point_z;
      logic [RANGE_BITS-1:0]        range_mm;
      logic [INTEN_BITS-1:0]        intensity;
      logic [ID_BITS-1:0]           laser_id;
   } point_type;

   typedef struct packed {
      logic [ID_BITS-1:0]    last_laser_id;
      logic [COUNT_BITS-1:0] frame_counter;
      logic                  frame_selected;
   } frame_status_type;

   localparam logic signed [COORD_BITS-1:0] COORD_MIN_RST = {1'b1, {(COORD_BITS-1){1'b0}}};
   localparam logic signed [COORD_BITS-1:0] COORD_MAX_RST = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic [RPC_BITS-1:0]          RPC_RST       = RPC_BITS'(2);

endpackage

### hw/rtl/lpwf_csr.sv
// ----------------------------------------------------------------------------
// lpwf_csr
// configuration register file, one register written per csr transfer
// ----------------------------------------------------------------------------
module lpwf_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   input  logic [lpwf_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [lpwf_pkg::CSR_DATA_BITS-1:0]   csr_data,
   output lpwf_pkg::cfg_type                    cfg
);
   import lpwf_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_X_BOUNDS: begin
               {cfg_in.x_max, cfg_in.x_min} = csr_data[2*COORD_BITS-1:0];
            end
            REG_Y_BOUNDS: begin
               {cfg_in.y_max, cfg_in.y_min} = csr_data[2*COORD_BITS-1:0];
            end
            REG_Z_BOUNDS: begin
               {cfg_in.z_max, cfg_in.z_min} = csr_data[2*COORD_BITS-1:0];
            end
            REG_DISTANCE_BOUNDS: begin
               {cfg_in.range_max, cfg_in.range_min} = csr_data[2*RANGE_BITS-1:0];
            end
            REG_INTENSITY_BOUNDS: begin
               {cfg_in.inten_max, cfg_in.inten_min} = csr_data[2*INTEN_BITS-1:0];
            end
            REG_RETURN_FILTER_ON: begin
               cfg_in.return_filter_on = csr_data[0];
            end
            REG_RETURNS_PER_CYC: begin
               cfg_in.returns_per_cycle = csr_data[RPC_BITS-1:0];
            end
            REG_KEPT_RETURN: begin
               cfg_in.kept_return = csr_data[COUNT_BITS-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.x_min             <= COORD_MIN_RST;
         cfg_ff.x_max             <= COORD_MAX_RST;
         cfg_ff.y_min             <= COORD_MIN_RST;
         cfg_ff.y_max             <= COORD_MAX_RST;
         cfg_ff.z_min             <= COORD_MIN_RST;
         cfg_ff.z_max             <= COORD_MAX_RST;
         cfg_ff.range_min         <= '0;
         cfg_ff.range_max         <= '1;
         cfg_ff.inten_min         <= '0;
         cfg_ff.inten_max         <= '1;
         cfg_ff.return_filter_on  <= 1'b0;
         cfg_ff.returns_per_cycle <= RPC_RST;
         cfg_ff.kept_return       <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### hw/rtl/lpwf_window.sv
// ----------------------------------------------------------------------------
// lpwf_window
// window test of one point: each value above its minimum, at most its maximum
// ----------------------------------------------------------------------------
module lpwf_window (
   input  lpwf_pkg::point_type  point,
   input  lpwf_pkg::cfg_type    cfg,
   output logic                 in_window
);
   import lpwf_pkg::*;

   logic x_ok;
   logic y_ok;
   logic z_ok;
   logic range_ok;
   logic inten_ok;

   // coordinate fields and bounds are declared signed in the package types
   assign x_ok     = (point.point_x > cfg.x_min) && (point.point_x <= cfg.x_max);
   assign y_ok     = (point.point_y > cfg.y_min) && (point.point_y <= cfg.y_max);
   assign z_ok     = (point.point_z > cfg.z_min) && (point.point_z <= cfg.z_max);
   assign range_ok = (point.range_mm > cfg.range_min) && (point.range_mm <= cfg.range_max);
   assign inten_ok = (point.intensity > cfg.inten_min) &&
                     (point.intensity <= cfg.inten_max);

   assign in_window = x_ok && y_ok && z_ok && range_ok && inten_ok;

endmodule

### hw/rtl/lpwf_frame.sv
// ----------------------------------------------------------------------------
// lpwf_frame
// return frame tracker: detects frame ends by laser id and picks the kept frame
// ----------------------------------------------------------------------------
module lpwf_frame (
   input  logic                          clock,
   input  logic                          reset,
   input  lpwf_pkg::cfg_type             cfg,
   input  logic [lpwf_pkg::ID_BITS-1:0]  laser_id,
   input  logic                          step,
   output logic                          selected,
   output lpwf_pkg::frame_status_type    status
);
   import lpwf_pkg::*;

   logic [ID_BITS-1:0]    last_id_ff;
   logic [ID_BITS-1:0]    last_id_in;
   logic [COUNT_BITS-1:0] counter_ff;
   logic [COUNT_BITS-1:0] counter_in;
   logic                  sel_ff;
   logic                  sel_in;
   logic                  frame_end;
   logic                  was_kept;
   logic                  wrap;

   assign frame_end = laser_id <= last_id_ff;
   assign was_kept  = counter_ff == cfg.kept_return;
   // wrap point is returns_per_cycle - 1 taken in five bits
   assign wrap      = {1'b0, counter_ff} == (cfg.returns_per_cycle - RPC_BITS'(1));

   always_comb begin
      last_id_in = last_id_ff;
      counter_in = counter_ff;
      sel_in     = sel_ff;
      if (cfg.return_filter_on) begin
         last_id_in = laser_id;
         if (frame_end) begin
            counter_in = wrap ? '0 : counter_ff + COUNT_BITS'(1);
            sel_in     = was_kept;
         end
      end
   end

   // the point closing a frame already follows the new selection
   assign selected = !cfg.return_filter_on || sel_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_id_ff <= '0;
         counter_ff <= '0;
         sel_ff     <= 1'b1;
      end else if (step) begin
         last_id_ff <= last_id_in;
         counter_ff <= counter_in;
         sel_ff     <= sel_in;
      end
   end

   assign status.last_laser_id  = last_id_ff;
   assign status.frame_counter  = counter_ff;
   assign status.frame_selected = sel_ff;

endmodule

### hw/rtl/lidar_point_window_filter_unit.sv
// ----------------------------------------------------------------------------
// lidar_point_window_filter_unit
// lidar point window filter with return frame selection
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_ready   point x/y/z, range, intensity, laser id
//   rsp      out        rsp_valid/rsp_ready   kept x/y/z, zero or one per point
//   csr      in         csr_valid/csr_ready   register index and write data
//
// one point per cycle sustained while rsp is not stalled; a point is held in the
// input register, and a kept point is written to the result register as it leaves
// the input register, setting rsp_valid; frame state moves as each point leaves.
// reset clears both valid bits, the frame state and the configuration registers.
// a stalled rsp holds its result; the input register still takes one more point,
// then req_ready stays low until the result transfers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lidar_point_window_filter_unit (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   output logic                                       req_ready,
   input  logic signed [lpwf_pkg::COORD_BITS-1:0]     req_point_x,
   input  logic signed [lpwf_pkg::COORD_BITS-1:0]     req_point_y,
   input  logic signed [lpwf_pkg::COORD_BITS-1:0]     req_point_z,
   input  logic        [lpwf_pkg::RANGE_BITS-1:0]     req_range_mm,
   input  logic        [lpwf_pkg::INTEN_BITS-1:0]     req_intensity,
   input  logic        [lpwf_pkg::ID_BITS-1:0]        req_laser_id,
   output logic                                       rsp_valid,
   input  logic                                       rsp_ready,
   output logic signed [lpwf_pkg::COORD_BITS-1:0]     rsp_kept_x,
   output logic signed [lpwf_pkg::COORD_BITS-1:0]     rsp_kept_y,
   output logic signed [lpwf_pkg::COORD_BITS-1:0]     rsp_kept_z,
   input  logic                                       csr_valid,
   output logic                                       csr_ready,
   input  logic        [lpwf_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic        [lpwf_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import lpwf_pkg::*;

   cfg_type                      cfg;
   point_type                    point_ff;
   point_type                    point_in;
   logic                         s1_valid_ff;
   logic                         s1_valid_in;
   logic                         s2_free;
   logic                         s1_move;
   logic                         req_fire;
   logic                         in_window;
   logic                         selected;
   logic                         keep;
   frame_status_type             frame_status;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic signed [COORD_BITS-1:0] kept_x_ff;
   logic signed [COORD_BITS-1:0] kept_y_ff;
   logic signed [COORD_BITS-1:0] kept_z_ff;

   assign csr_ready = 1'b1;

   lpwf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // result register can take a new value when empty or being drained
   assign s2_free   = !rsp_valid_ff || rsp_ready;
   assign s1_move   = s1_valid_ff && s2_free;
   assign req_ready = !s1_valid_ff || s2_free;
   assign req_fire  = req_valid && req_ready;

   assign point_in.point_x   = req_point_x;
   assign point_in.point_y   = req_point_y;
   assign point_in.point_z   = req_point_z;
   assign point_in.range_mm  = req_range_mm;
   assign point_in.intensity = req_intensity;
   assign point_in.laser_id  = req_laser_id;

   assign s1_valid_in = req_fire || (s1_valid_ff && !s2_free);

   lpwf_window u_window (
      .point     (point_ff),
      .cfg       (cfg),
      .in_window (in_window)
   );

   lpwf_frame u_frame (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .laser_id (point_ff.laser_id),
      .step     (s1_move),
      .selected (selected),
      .status   (frame_status)
   );

   assign keep = in_window && selected;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (s1_move) begin
         rsp_valid_in = keep;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         point_ff <= point_in;
      end
      if (s1_move && keep) begin
         kept_x_ff <= point_ff.point_x;
         kept_y_ff <= point_ff.point_y;
         kept_z_ff <= point_ff.point_z;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_kept_x = kept_x_ff;
   assign rsp_kept_y = kept_y_ff;
   assign rsp_kept_z = kept_z_ff;

   // a held input item blocks new transfers
   `ASSERT_SAME(a_hold_blocks_req, s1_valid_ff && !s2_free, !req_ready)
   // frame state never moves while return filtering is off
   `ASSERT_NEXT(a_frame_idle_when_off, !cfg.return_filter_on, $stable(frame_status))
   // a new result only comes from an item leaving the input register
   `ASSERT_SAME(a_result_has_source, $rose(rsp_valid_ff), $past(s1_move))

endmodule

### sim/point_filter_checker.sv
// ----------------------------------------------------------------------------
// point_filter_checker
// watches the point, result and register channels of the window filter, keeps
// its own copy of the windows and the return frame state, predicts the kept
// points in order and compares each result transfer field by field
// ----------------------------------------------------------------------------
module point_filter_checker (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   input  logic                                    req_ready,
   input  logic signed [lpwf_pkg::COORD_BITS-1:0]  req_point_x,
   input  logic signed [lpwf_pkg::COORD_BITS-1:0]  req_point_y,
   input  logic signed [lpwf_pkg::COORD_BITS-1:0]  req_point_z,
   input  logic        [lpwf_pkg::RANGE_BITS-1:0]  req_range_mm,
   input  logic        [lpwf_pkg::INTEN_BITS-1:0]  req_intensity,
   input  logic        [lpwf_pkg::ID_BITS-1:0]     req_laser_id,
   input  logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   input  logic signed [lpwf_pkg::COORD_BITS-1:0]  rsp_kept_x,
   input  logic signed [lpwf_pkg::COORD_BITS-1:0]  rsp_kept_y,
   input  logic signed [lpwf_pkg::COORD_BITS-1:0]  rsp_kept_z,
   input  logic                                    csr_valid,
   input  logic                                    csr_ready,
   input  logic [lpwf_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [lpwf_pkg::CSR_DATA_BITS-1:0]      csr_data,
   output int                                      expected_left,
   output int                                      kept_total,
   output int                                      mismatches
);
   import lpwf_pkg::*;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic signed [COORD_BITS-1:0] z;
   } coord_type;

   cfg_type               cfg;
   logic [ID_BITS-1:0]    prev_id;
   logic [COUNT_BITS-1:0] frame_count;
   logic                  frame_kept;
   coord_type             coords_due[$];

   initial begin
      expected_left = 0;
      kept_total    = 0;
      mismatches    = 0;
   end

   function automatic bit coord_in_window(input logic signed [COORD_BITS-1:0] v, lo, hi);
      return (v > lo) && (v <= hi);
   endfunction

   function automatic bit level_in_window(input logic [RANGE_BITS-1:0] v, lo, hi);
      return (v > lo) && (v <= hi);
   endfunction

   task automatic report_mismatch(input string msg);
      $display("point filter check at %0t: %s", $time, msg);
      mismatches++;
   endtask

   always @(posedge clock) begin : track
      coord_type got;
      coord_type want;
      logic      frame_end;
      logic      was_kept;
      logic      selected;
      logic      windows_ok;
      if (reset) begin
         cfg.x_min             = COORD_MIN_RST;
         cfg.x_max             = COORD_MAX_RST;
         cfg.y_min             = COORD_MIN_RST;
         cfg.y_max             = COORD_MAX_RST;
         cfg.z_min             = COORD_MIN_RST;
         cfg.z_max             = COORD_MAX_RST;
         cfg.range_min         = '0;
         cfg.range_max         = '1;
         cfg.inten_min         = '0;
         cfg.inten_max         = '1;
         cfg.return_filter_on  = 1'b0;
         cfg.returns_per_cycle = RPC_RST;
         cfg.kept_return       = '0;
         prev_id               = '0;
         frame_count           = '0;
         frame_kept            = 1'b1;
         coords_due.delete();
      end else begin
         // results first: a transfer in this cycle belongs to an older point
         if (rsp_valid && rsp_ready) begin
            got.x = rsp_kept_x;
            got.y = rsp_kept_y;
            got.z = rsp_kept_z;
            if (coords_due.size() == 0) begin
               report_mismatch($sformatf("point (%0d, %0d, %0d) with none expected",
                                         got.x, got.y, got.z));
            end else begin
               want = coords_due.pop_front();
               if (got.x !== want.x)
                  report_mismatch($sformatf("kept_x %0d, expected %0d", got.x, want.x));
               if (got.y !== want.y)
                  report_mismatch($sformatf("kept_y %0d, expected %0d", got.y, want.y));
               if (got.z !== want.z)
                  report_mismatch($sformatf("kept_z %0d, expected %0d", got.z, want.z));
               kept_total++;
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               REG_X_BOUNDS:         {cfg.x_max, cfg.x_min} = csr_data;
               REG_Y_BOUNDS:         {cfg.y_max, cfg.y_min} = csr_data;
               REG_Z_BOUNDS:         {cfg.z_max, cfg.z_min} = csr_data;
               REG_DISTANCE_BOUNDS:  {cfg.range_max, cfg.range_min} = csr_data;
               REG_INTENSITY_BOUNDS: {cfg.inten_max, cfg.inten_min} = csr_data[2*INTEN_BITS-1:0];
               REG_RETURN_FILTER_ON: cfg.return_filter_on = csr_data[0];
               REG_RETURNS_PER_CYC:  cfg.returns_per_cycle = csr_data[RPC_BITS-1:0];
               REG_KEPT_RETURN:      cfg.kept_return = csr_data[COUNT_BITS-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            selected = 1'b1;
            if (cfg.return_filter_on) begin
               frame_end = (req_laser_id <= prev_id);
               was_kept  = (frame_count == cfg.kept_return);
               prev_id   = req_laser_id;
               if (frame_end) begin
                  // wrap point is the cycle length less one, taken in 5 bits
                  if (RPC_BITS'(frame_count) == RPC_BITS'(cfg.returns_per_cycle - 1'b1))
                     frame_count = '0;
                  else
                     frame_count = frame_count + 1'b1;
                  frame_kept = was_kept;
               end
               selected = frame_kept;
            end
            windows_ok = coord_in_window(req_point_x, cfg.x_min, cfg.x_max) &&
                         coord_in_window(req_point_y, cfg.y_min, cfg.y_max) &&
                         coord_in_window(req_point_z, cfg.z_min, cfg.z_max) &&
                         level_in_window(req_range_mm, cfg.range_min, cfg.range_max) &&
                         level_in_window(RANGE_BITS'(req_intensity),
                                         RANGE_BITS'(cfg.inten_min),
                                         RANGE_BITS'(cfg.inten_max));
            if (selected && windows_ok) begin
               want.x = req_point_x;
               want.y = req_point_y;
               want.z = req_point_z;
               coords_due.insert(coords_due.size(), want);
            end
         end
      end
      expected_left = coords_due.size();
   end

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives lidar points and register settings into the window filter: a short
// directed run over window edges and frame selection cases, then phases of
// random settings with frame-shaped laser id streams and random stalls on
// both channels; point_filter_checker predicts and compares the kept points
// ----------------------------------------------------------------------------
module testbench;

   import lpwf_pkg::*;

   localparam int RANDOM_POINTS = 1600;
   localparam int PHASE_POINTS  = 100;
   localparam int ID_TOP        = (1 << ID_BITS) - 1;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic signed [COORD_BITS-1:0]  req_point_x;
   logic signed [COORD_BITS-1:0]  req_point_y;
   logic signed [COORD_BITS-1:0]  req_point_z;
   logic        [RANGE_BITS-1:0]  req_range_mm;
   logic        [INTEN_BITS-1:0]  req_intensity;
   logic        [ID_BITS-1:0]     req_laser_id;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic signed [COORD_BITS-1:0]  rsp_kept_x;
   logic signed [COORD_BITS-1:0]  rsp_kept_y;
   logic signed [COORD_BITS-1:0]  rsp_kept_z;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [CSR_INDEX_BITS-1:0]     csr_index;
   logic [CSR_DATA_BITS-1:0]      csr_data;

   int   expected_left;
   int   kept_total;
   int   mismatches;
   int   points_sent    = 0;
   int   settings_used  = 0;
   bit   quiet          = 1'b0;

   byte unsigned frame_ids[12] = '{1, 2, 3, 0, 1, 5, 5, 9, 200, 0, 255, 0};

   lidar_point_window_filter_unit DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_point_x   (req_point_x),
      .req_point_y   (req_point_y),
      .req_point_z   (req_point_z),
      .req_range_mm  (req_range_mm),
      .req_intensity (req_intensity),
      .req_laser_id  (req_laser_id),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_kept_x    (rsp_kept_x),
      .rsp_kept_y    (rsp_kept_y),
      .rsp_kept_z    (rsp_kept_z),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   point_filter_checker filter_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_point_x   (req_point_x),
      .req_point_y   (req_point_y),
      .req_point_z   (req_point_z),
      .req_range_mm  (req_range_mm),
      .req_intensity (req_intensity),
      .req_laser_id  (req_laser_id),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_kept_x    (rsp_kept_x),
      .rsp_kept_y    (rsp_kept_y),
      .rsp_kept_z    (rsp_kept_z),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .expected_left (expected_left),
      .kept_total    (kept_total),
      .mismatches    (mismatches)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result side is stalled with probability 7 in 100, never during a quiet stretch
   always @(posedge clock) begin
      rsp_ready <= quiet || ($urandom_range(0, 99) >= 7);
   end

   initial begin
      #5_000_000;
      $display("timeout waiting for the point filter");
      $display("lidar_point_window_filter_unit: mismatch");
      $finish;
   end

   task automatic send_point(input logic signed [COORD_BITS-1:0] x, y, z,
                             input logic [RANGE_BITS-1:0] range_mm,
                             input logic [INTEN_BITS-1:0] intensity,
                             input logic [ID_BITS-1:0] laser_id);
      int gap;
      gap = (quiet || $urandom_range(0, 99) >= 7) ? 0 : $urandom_range(1, 4);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_point_x   <= x;
      req_point_y   <= y;
      req_point_z   <= z;
      req_range_mm  <= range_mm;
      req_intensity <= intensity;
      req_laser_id  <= laser_id;
      do @(posedge clock); while (!req_ready);
      points_sent++;
   endtask

   // bits above the register width carry noise, the block must drop them
   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] value,
                            input int width);
      logic [CSR_DATA_BITS-1:0] junk;
      junk = CSR_DATA_BITS'({$urandom, $urandom});
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= (width >= CSR_DATA_BITS) ? value : ((junk << width) | value);
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic load_setting(input cfg_type s);
      write_reg(REG_X_BOUNDS, {s.x_max, s.x_min}, CSR_DATA_BITS);
      write_reg(REG_Y_BOUNDS, {s.y_max, s.y_min}, CSR_DATA_BITS);
      write_reg(REG_Z_BOUNDS, {s.z_max, s.z_min}, CSR_DATA_BITS);
      write_reg(REG_DISTANCE_BOUNDS, {s.range_max, s.range_min}, CSR_DATA_BITS);
      write_reg(REG_INTENSITY_BOUNDS, CSR_DATA_BITS'({s.inten_max, s.inten_min}),
                2 * INTEN_BITS);
      write_reg(REG_RETURN_FILTER_ON, CSR_DATA_BITS'(s.return_filter_on), 1);
      write_reg(REG_RETURNS_PER_CYC, CSR_DATA_BITS'(s.returns_per_cycle), RPC_BITS);
      write_reg(REG_KEPT_RETURN, CSR_DATA_BITS'(s.kept_return), COUNT_BITS);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // idle the point side, wait for every kept point, then let the pipe empty
   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (expected_left != 0);
      repeat (6) @(negedge clock);
      @(posedge clock);
   endtask

   function automatic cfg_type reset_setting();
      cfg_type s;
      s.x_min             = COORD_MIN_RST;
      s.x_max             = COORD_MAX_RST;
      s.y_min             = COORD_MIN_RST;
      s.y_max             = COORD_MAX_RST;
      s.z_min             = COORD_MIN_RST;
      s.z_max             = COORD_MAX_RST;
      s.range_min         = '0;
      s.range_max         = '1;
      s.inten_min         = '0;
      s.inten_max         = '1;
      s.return_filter_on  = 1'b0;
      s.returns_per_cycle = RPC_RST;
      s.kept_return       = '0;
      return s;
   endfunction

   function automatic void pick_coord_window(output logic signed [COORD_BITS-1:0] lo, hi);
      logic signed [COORD_BITS-1:0] a;
      logic signed [COORD_BITS-1:0] b;
      a = COORD_BITS'($urandom);
      b = COORD_BITS'($urandom);
      case ($urandom_range(0, 19))
         0, 1: begin lo = COORD_MIN_RST; hi = COORD_MAX_RST; end
         2:    begin lo = (a > b) ? a : b; hi = (a > b) ? b : a; end  // empty window
         3:    begin lo = COORD_MIN_RST; hi = a; end
         4:    begin lo = a; hi = COORD_MAX_RST; end
         default: begin lo = (a < b) ? a : b; hi = (a < b) ? b : a; end
      endcase
   endfunction

   function automatic void pick_level_window(input int bits,
                                             output logic [RANGE_BITS-1:0] lo, hi);
      logic [RANGE_BITS-1:0] a;
      logic [RANGE_BITS-1:0] b;
      logic [RANGE_BITS-1:0] top_val;
      top_val = RANGE_BITS'((longint'(1) << bits) - 1);
      a = RANGE_BITS'($urandom) & top_val;
      b = RANGE_BITS'($urandom) & top_val;
      case ($urandom_range(0, 19))
         0, 1: begin lo = '0; hi = top_val; end
         2:    begin lo = (a > b) ? a : b; hi = (a > b) ? b : a; end
         3:    begin lo = '0; hi = a; end
         4:    begin lo = a; hi = top_val; end
         default: begin lo = (a < b) ? a : b; hi = (a < b) ? b : a; end
      endcase
   endfunction

   // mostly inside the window, with its edges, the field extremes and noise
   function automatic logic signed [COORD_BITS-1:0] pick_coord(
         input logic signed [COORD_BITS-1:0] lo, hi);
      int span;
      logic signed [COORD_BITS-1:0] v;
      span = int'(hi) - int'(lo);
      case ($urandom_range(0, 39))
         0: v = lo;
         1: v = COORD_BITS'(lo + 1);
         2: v = hi;
         3: v = COORD_BITS'(hi + 1);
         4: v = $urandom_range(0, 1) ? COORD_MIN_RST : COORD_MAX_RST;
         5, 6: v = COORD_BITS'($urandom);
         default: begin
            if (span > 0)
               v = COORD_BITS'(int'(lo) + 1 + int'($urandom_range(0, span - 1)));
            else
               v = COORD_BITS'($urandom);
         end
      endcase
      return v;
   endfunction

   function automatic logic [RANGE_BITS-1:0] pick_level(input int bits,
                                                        input logic [RANGE_BITS-1:0] lo, hi);
      longint span;
      logic [RANGE_BITS-1:0] top_val;
      logic [RANGE_BITS-1:0] v;
      top_val = RANGE_BITS'((longint'(1) << bits) - 1);
      span = longint'(hi) - longint'(lo);
      case ($urandom_range(0, 39))
         0: v = lo;
         1: v = lo + 1'b1;
         2: v = hi;
         3: v = hi + 1'b1;
         4: v = $urandom_range(0, 1) ? top_val : '0;
         5, 6: v = RANGE_BITS'($urandom);
         default: begin
            if (span > 0)
               v = RANGE_BITS'(longint'(lo) + 1 + longint'($urandom_range(0, span - 1)));
            else
               v = RANGE_BITS'($urandom);
         end
      endcase
      return v & top_val;
   endfunction

   initial begin : stimulus
      cfg_type                  s;
      logic [RANGE_BITS-1:0]    ilo;
      logic [RANGE_BITS-1:0]    ihi;
      logic [ID_BITS-1:0]       cur_id;
      logic [ID_BITS-1:0]       id;
      int                       nid;
      int                       phase;
      int                       roll;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_point_x   = '0;
      req_point_y   = '0;
      req_point_z   = '0;
      req_range_mm  = '0;
      req_intensity = '0;
      req_laser_id  = '0;
      csr_valid     = 1'b0;
      csr_index     = '0;
      csr_data      = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // window edges under the reset windows, filtering off
      send_point(COORD_MIN_RST, 0, 0, 1, 1, 0);
      send_point(COORD_MAX_RST, COORD_MAX_RST, COORD_MAX_RST, '1, '1, '1);
      send_point(0, COORD_MIN_RST, 0, 1, 1, 0);
      send_point(0, 0, COORD_MIN_RST, 1, 1, 0);
      send_point(-5, 7, -9, 0, 1, 3);
      send_point(-5, 7, -9, 1, 0, 3);
      send_point(COORD_MIN_RST + 1, COORD_MIN_RST + 1, COORD_MIN_RST + 1, 1, 1, 2);
      send_point(123, -456, 789, 24'h800000, 16'h8000, 8'h80);
      drain();

      // two-frame cycle keeping the second frame, ids end frames on drop and repeat
      s = reset_setting();
      s.return_filter_on = 1'b1;
      s.kept_return      = 1;
      load_setting(s);
      foreach (frame_ids[k])
         send_point(k * 100, -k * 100, k, 1000, 100, frame_ids[k]);
      drain();

      // empty x window with filtering off, frame state must stay as it was
      s = reset_setting();
      s.x_min = 0;
      s.x_max = 0;
      load_setting(s);
      send_point(0, 1, 1, 1, 1, 9);
      send_point(1, 1, 1, 1, 1, 4);
      drain();

      // kept index beyond the cycle: nothing survives after the first frame end
      s = reset_setting();
      s.return_filter_on  = 1'b1;
      s.returns_per_cycle = 3;
      s.kept_return       = 5;
      load_setting(s);
      send_point(11, 12, 13, 50, 50, 3);
      send_point(21, 22, 23, 50, 50, 2);
      send_point(31, 32, 33, 50, 50, 1);
      send_point(41, 42, 43, 50, 50, 0);
      drain();

      cur_id = '0;
      phase  = 0;
      while (phase * PHASE_POINTS < RANDOM_POINTS) begin
         quiet <= (phase >= 5 && phase < 8);
         pick_coord_window(s.x_min, s.x_max);
         pick_coord_window(s.y_min, s.y_max);
         pick_coord_window(s.z_min, s.z_max);
         pick_level_window(RANGE_BITS, s.range_min, s.range_max);
         pick_level_window(INTEN_BITS, ilo, ihi);
         s.inten_min = INTEN_BITS'(ilo);
         s.inten_max = INTEN_BITS'(ihi);
         s.return_filter_on = ($urandom_range(0, 4) != 0);
         case ($urandom_range(0, 9))
            0:       s.returns_per_cycle = 0;
            1:       s.returns_per_cycle = 16;
            2:       s.returns_per_cycle = RPC_BITS'($urandom_range(17, 31));
            3:       s.returns_per_cycle = 1;
            default: s.returns_per_cycle = RPC_BITS'($urandom_range(2, 4));
         endcase
         if ($urandom_range(0, 3) == 0 || s.returns_per_cycle == 0 || s.returns_per_cycle > 16)
            s.kept_return = COUNT_BITS'($urandom_range(0, 15));
         else
            s.kept_return = COUNT_BITS'($urandom_range(0, s.returns_per_cycle - 1));
         load_setting(s);

         repeat (PHASE_POINTS) begin
            // rising ids within a frame, a drop or repeat ends it, some noise
            roll = $urandom_range(0, 99);
            if (roll < 10) begin
               id = ID_BITS'($urandom);
            end else if (roll < 28 || cur_id == ID_TOP) begin
               id = ID_BITS'($urandom_range(0, cur_id));
            end else begin
               nid = int'(cur_id) + $urandom_range(1, 3);
               id  = (nid > ID_TOP) ? ID_BITS'(ID_TOP) : ID_BITS'(nid);
            end
            cur_id = id;
            send_point(pick_coord(s.x_min, s.x_max), pick_coord(s.y_min, s.y_max),
                       pick_coord(s.z_min, s.z_max),
                       pick_level(RANGE_BITS, s.range_min, s.range_max),
                       INTEN_BITS'(pick_level(INTEN_BITS, ilo, ihi)), id);
         end
         drain();
         phase++;
      end

      $display("sent %0d points under %0d register settings, %0d kept points compared",
               points_sent, settings_used, kept_total);
      if (mismatches == 0 && expected_left == 0) begin
         $display("lidar_point_window_filter_unit: match");
      end else begin
         $display("lidar_point_window_filter_unit: mismatch");
      end
      $finish;
   end

endmodule
